### design/afk_pkg.sv
package afk_pkg;

    localparam int ANGLE_W      = 16;
    localparam int POS_W        = 20;
    localparam int SPD_W        = POS_W + 5;
    localparam int ACC_W        = POS_W + 12;
    localparam int CFG_W        = 10;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int NUM_JOINTS   = 6;
    localparam int JOINT_W      = 3;
    localparam int NUM_ROT      = 9;
    localparam int ROT_W        = 4;
    localparam int NUM_AXES     = 3;
    localparam int AXIS_W       = 2;
    localparam int ZFRAC        = 28;
    localparam int ZSHIFT       = ZFRAC - (ANGLE_W - 4);
    localparam int Z_W          = 33;
    localparam int CX_W         = 32;
    localparam int CS_W         = 19;
    localparam int VEC_W        = 30;
    localparam int MUL_W        = CS_W + VEC_W;
    localparam int IN_W         = NUM_JOINTS * ANGLE_W;
    localparam int OUT_USED     = NUM_AXES * (2 * POS_W + SPD_W + ACC_W);
    localparam int OUT_W        = ((OUT_USED + 7) / 8) * 8;
    localparam int ADDR_W       = 4;

    localparam logic signed [Z_W-1:0]  PI_Z        = 33'sd843314857;
    localparam logic signed [Z_W-1:0]  TWO_PI_Z    = 33'sd1686629713;
    localparam logic signed [Z_W-1:0]  HALF_PI_Z   = 33'sd421657428;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 32'sd163008219;

    localparam logic [CFG_W-1:0] RST_UPPER_ARM = 10'd275;
    localparam logic [CFG_W-1:0] RST_FOREARM   = 10'd270;
    localparam logic [CFG_W-1:0] RST_TOOL      = 10'd79;
    localparam logic [CFG_W-1:0] RST_RATE      = 10'd20;

    typedef enum logic [1:0] {
        REG_UPPER_ARM,
        REG_FOREARM,
        REG_TOOL,
        REG_RATE
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ITER,
        S_STORE,
        S_ROT1,
        S_ROT2,
        S_ROT3,
        S_SPD,
        S_ACC,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        ROT_A,
        ROT_B,
        ROT_C
    } t_rot_kind;

    typedef struct packed {
        logic               use_tool;
        logic [JOINT_W-1:0] joint;
        t_rot_kind          kind;
        logic               add_upper;
    } t_rot_info;

    typedef struct packed {
        logic [CFG_W-1:0] upper_arm;
        logic [CFG_W-1:0] forearm;
        logic [CFG_W-1:0] tool;
        logic [CFG_W-1:0] rate;
    } t_cfg;

    typedef struct packed {
        logic               accept;
        logic               cordic_load;
        logic               cordic_step;
        logic [STEP_W-1:0]  step;
        logic [JOINT_W-1:0] joint;
        logic               cs_store;
        logic               rot1;
        logic               rot2;
        logic               rot3;
        logic [ROT_W-1:0]   rot;
        logic               spd;
        logic               acc;
        logic [AXIS_W-1:0]  axis;
        logic               out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

    // atan(2^-i) in Q28
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        case (i)
            4'd0:    atan_entry = 33'sd210828714;
            4'd1:    atan_entry = 33'sd124459457;
            4'd2:    atan_entry = 33'sd65760959;
            4'd3:    atan_entry = 33'sd33381290;
            4'd4:    atan_entry = 33'sd16755422;
            4'd5:    atan_entry = 33'sd8385879;
            4'd6:    atan_entry = 33'sd4193963;
            4'd7:    atan_entry = 33'sd2097109;
            4'd8:    atan_entry = 33'sd1048571;
            4'd9:    atan_entry = 33'sd524287;
            4'd10:   atan_entry = 33'sd262144;
            4'd11:   atan_entry = 33'sd131072;
            4'd12:   atan_entry = 33'sd65536;
            4'd13:   atan_entry = 33'sd32768;
            4'd14:   atan_entry = 33'sd16384;
            default: atan_entry = 33'sd8192;
        endcase
    endfunction

    // rotation schedule: flange chain first, then tool chain from joint six back to joint one
    function automatic t_rot_info rot_info(input logic [ROT_W-1:0] idx);
        t_rot_info r;
        r.use_tool  = 1'b1;
        r.add_upper = 1'b0;
        r.kind      = ROT_A;
        r.joint     = 3'd0;
        case (idx)
            4'd0: begin r.use_tool = 1'b0; r.joint = 3'd2; r.kind = ROT_A; r.add_upper = 1'b1; end
            4'd1: begin r.use_tool = 1'b0; r.joint = 3'd1; r.kind = ROT_B; end
            4'd2: begin r.use_tool = 1'b0; r.joint = 3'd0; r.kind = ROT_A; end
            4'd3: begin r.joint = 3'd5; r.kind = ROT_B; end
            4'd4: begin r.joint = 3'd4; r.kind = ROT_C; end
            4'd5: begin r.joint = 3'd3; r.kind = ROT_B; end
            4'd6: begin r.joint = 3'd2; r.kind = ROT_A; end
            4'd7: begin r.joint = 3'd1; r.kind = ROT_B; end
            default: begin r.joint = 3'd0; r.kind = ROT_A; end
        endcase
        return r;
    endfunction

endpackage

### design/afk_cordic.sv
module afk_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_step,
    input  logic [afk_pkg::STEP_W-1:0]           i_step_idx,
    input  logic signed [afk_pkg::ANGLE_W-1:0]   i_angle,
    output logic signed [afk_pkg::CS_W-1:0]      o_cos,
    output logic signed [afk_pkg::CS_W-1:0]      o_sin
);
    import afk_pkg::*;

    logic signed [Z_W-1:0]  w_a0, w_a1, w_a2;
    logic                   w_flip;
    logic signed [Z_W-1:0]  r_a;
    logic signed [CX_W-1:0] r_x, r_y;
    logic                   r_flip;
    logic signed [CX_W-1:0] w_dx, w_dy, w_xr, w_yr;
    logic signed [Z_W-1:0]  w_tab;
    logic signed [CS_W-1:0] w_c, w_s;

    // range reduction: one wrap covers the whole input range
    always_comb begin
        w_a0 = Z_W'(i_angle) <<< ZSHIFT;
        if (w_a0 > PI_Z) begin
            w_a1 = w_a0 - TWO_PI_Z;
        end else if (w_a0 < -PI_Z) begin
            w_a1 = w_a0 + TWO_PI_Z;
        end else begin
            w_a1 = w_a0;
        end
        w_flip = 1'b0;
        if (w_a1 > HALF_PI_Z) begin
            w_a2   = w_a1 - PI_Z;
            w_flip = 1'b1;
        end else if (w_a1 < -HALF_PI_Z) begin
            w_a2   = w_a1 + PI_Z;
            w_flip = 1'b1;
        end else begin
            w_a2 = w_a1;
        end
    end

    assign w_dx  = r_y >>> i_step_idx;
    assign w_dy  = r_x >>> i_step_idx;
    assign w_tab = atan_entry(i_step_idx);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a    <= w_a2;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_flip <= w_flip;
        end else if (i_step) begin
            if (r_a >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_a <= r_a - w_tab;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_a <= r_a + w_tab;
            end
        end
    end

    // round Q28 to Q16, half up
    assign w_xr  = (r_x + CX_W'(2048)) >>> 12;
    assign w_yr  = (r_y + CX_W'(2048)) >>> 12;
    assign w_c   = CS_W'(w_xr);
    assign w_s   = CS_W'(w_yr);
    assign o_cos = r_flip ? -w_c : w_c;
    assign o_sin = r_flip ? -w_s : w_s;

endmodule

### design/afk_datapath.sv
module afk_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  afk_pkg::t_cmd                 i_cmd,
    input  afk_pkg::t_cfg                 i_cfg,
    input  logic [afk_pkg::IN_W-1:0]      i_s_tdata,
    input  logic                          i_m_tready,
    output afk_pkg::t_status              o_status,
    output logic                          o_m_tvalid,
    output logic [afk_pkg::OUT_W-1:0]     o_m_tdata
);
    import afk_pkg::*;

    logic signed [ANGLE_W-1:0] r_ang [NUM_JOINTS];
    logic signed [CS_W-1:0]    r_cos [NUM_JOINTS];
    logic signed [CS_W-1:0]    r_sin [NUM_JOINTS];
    logic signed [VEC_W-1:0]   r_fl  [NUM_AXES];
    logic signed [VEC_W-1:0]   r_tl  [NUM_AXES];
    logic signed [MUL_W-1:0]   r_m0, r_m1;
    logic signed [VEC_W-1:0]   r_u;
    logic signed [POS_W-1:0]   r_pos [NUM_AXES];
    logic signed [POS_W-1:0]   r_tip [NUM_AXES];
    logic signed [SPD_W-1:0]   r_spd [NUM_AXES];
    logic signed [ACC_W-1:0]   r_acc [NUM_AXES];
    logic signed [POS_W-1:0]   r_prev_pos [NUM_AXES];
    logic signed [SPD_W-1:0]   r_prev_spd [NUM_AXES];
    logic                      r_first;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    logic signed [CS_W-1:0]    w_cord_cos, w_cord_sin;
    t_rot_info                 w_info;
    logic signed [CS_W-1:0]    w_c, w_s;
    logic signed [VEC_W-1:0]   w_vx, w_vy, w_vz;
    logic signed [MUL_W:0]     w_sum_u, w_sum_w;
    logic signed [VEC_W-1:0]   w_new_u, w_w, w_nx;
    logic signed [VEC_W-1:0]   w_ny, w_nz;
    logic signed [VEC_W:0]     w_f_ext, w_ft, w_posr, w_tipr;
    logic signed [POS_W-1:0]   w_pos, w_tip;
    logic signed [CFG_W:0]     w_rate;
    logic signed [POS_W:0]     w_dpos;
    logic signed [POS_W+CFG_W+1:0] w_sprod;
    logic signed [SPD_W-1:0]   w_spd;
    logic signed [SPD_W:0]     w_dspd;
    logic signed [SPD_W+CFG_W+1:0] w_aprod;
    logic signed [ACC_W-1:0]   w_acc;
    logic [OUT_W-1:0]          w_pack;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    afk_cordic u_cordic (
        .i_clk      (i_clk),
        .i_load     (i_cmd.cordic_load),
        .i_step     (i_cmd.cordic_step),
        .i_step_idx (i_cmd.step),
        .i_angle    (r_ang[i_cmd.joint]),
        .o_cos      (w_cord_cos),
        .o_sin      (w_cord_sin)
    );

    // rotation: u = c*x - s*y, w = s*x + c*y, each rounded once
    always_comb begin
        w_info  = rot_info(i_cmd.rot);
        w_c     = r_cos[w_info.joint];
        w_s     = r_sin[w_info.joint];
        w_vx    = w_info.use_tool ? r_tl[0] : r_fl[0];
        w_vy    = w_info.use_tool ? r_tl[1] : r_fl[1];
        w_vz    = w_info.use_tool ? r_tl[2] : r_fl[2];
        w_sum_u = (MUL_W+1)'(r_m0) - (MUL_W+1)'(r_m1) + (MUL_W+1)'(32768);
        w_sum_w = (MUL_W+1)'(r_m0) + (MUL_W+1)'(r_m1) + (MUL_W+1)'(32768);
        w_new_u = VEC_W'(w_sum_u >>> 16);
        w_w     = VEC_W'(w_sum_w >>> 16);
        w_nx    = w_info.add_upper ? r_u + VEC_W'({i_cfg.upper_arm, 16'b0}) : r_u;
        case (w_info.kind)
            ROT_B: begin
                w_ny = w_vz;
                w_nz = -w_w;
            end
            ROT_C: begin
                w_ny = -w_vz;
                w_nz = w_w;
            end
            default: begin
                w_ny = w_w;
                w_nz = w_vz;
            end
        endcase
    end

    // per-axis position, speed and acceleration
    always_comb begin
        w_f_ext = (VEC_W+1)'(r_fl[i_cmd.axis]);
        w_ft    = w_f_ext + (VEC_W+1)'(r_tl[i_cmd.axis]);
        w_posr  = (w_f_ext + (VEC_W+1)'(128)) >>> 8;
        w_tipr  = (w_ft + (VEC_W+1)'(128)) >>> 8;
        if (w_posr > (VEC_W+1)'(POS_MAX)) begin
            w_pos = POS_MAX;
        end else if (w_posr < (VEC_W+1)'(POS_MIN)) begin
            w_pos = POS_MIN;
        end else begin
            w_pos = POS_W'(w_posr);
        end
        if (w_tipr > (VEC_W+1)'(POS_MAX)) begin
            w_tip = POS_MAX;
        end else if (w_tipr < (VEC_W+1)'(POS_MIN)) begin
            w_tip = POS_MIN;
        end else begin
            w_tip = POS_W'(w_tipr);
        end
        w_rate  = $signed({1'b0, i_cfg.rate});
        w_dpos  = (POS_W+1)'(w_pos) - (POS_W+1)'(r_prev_pos[i_cmd.axis]);
        w_sprod = (POS_W+CFG_W+2)'(w_dpos) * (POS_W+CFG_W+2)'(w_rate);
        if (r_first) begin
            w_spd = '0;
        end else if (w_sprod > (POS_W+CFG_W+2)'(SPD_MAX)) begin
            w_spd = SPD_MAX;
        end else if (w_sprod < (POS_W+CFG_W+2)'(SPD_MIN)) begin
            w_spd = SPD_MIN;
        end else begin
            w_spd = SPD_W'(w_sprod);
        end
        w_dspd  = (SPD_W+1)'(r_spd[i_cmd.axis]) - (SPD_W+1)'(r_prev_spd[i_cmd.axis]);
        w_aprod = (SPD_W+CFG_W+2)'(w_dspd) * (SPD_W+CFG_W+2)'(w_rate);
        if (r_first) begin
            w_acc = '0;
        end else if (w_aprod > (SPD_W+CFG_W+2)'(ACC_MAX)) begin
            w_acc = ACC_MAX;
        end else if (w_aprod < (SPD_W+CFG_W+2)'(ACC_MIN)) begin
            w_acc = ACC_MIN;
        end else begin
            w_acc = ACC_W'(w_aprod);
        end
    end

    always_comb begin
        w_pack = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            w_pack[k*POS_W +: POS_W]                            = r_tip[k];
            w_pack[(NUM_AXES+k)*POS_W +: POS_W]                 = r_pos[k];
            w_pack[2*NUM_AXES*POS_W + k*SPD_W +: SPD_W]         = r_spd[k];
            w_pack[2*NUM_AXES*POS_W + NUM_AXES*SPD_W + k*ACC_W +: ACC_W] = r_acc[k];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_ang[j] <= i_s_tdata[j*ANGLE_W +: ANGLE_W];
            end
            r_fl[0] <= '0;
            r_fl[1] <= VEC_W'({i_cfg.forearm, 16'b0});
            r_fl[2] <= '0;
            r_tl[0] <= '0;
            r_tl[1] <= '0;
            r_tl[2] <= VEC_W'({i_cfg.tool, 16'b0});
        end
        if (i_cmd.cs_store) begin
            r_cos[i_cmd.joint] <= w_cord_cos;
            r_sin[i_cmd.joint] <= w_cord_sin;
        end
        if (i_cmd.rot1) begin
            r_m0 <= MUL_W'(w_c) * MUL_W'(w_vx);
            r_m1 <= MUL_W'(w_s) * MUL_W'(w_vy);
        end
        if (i_cmd.rot2) begin
            r_u  <= w_new_u;
            r_m0 <= MUL_W'(w_s) * MUL_W'(w_vx);
            r_m1 <= MUL_W'(w_c) * MUL_W'(w_vy);
        end
        if (i_cmd.rot3) begin
            if (w_info.use_tool) begin
                r_tl[0] <= w_nx;
                r_tl[1] <= w_ny;
                r_tl[2] <= w_nz;
            end else begin
                r_fl[0] <= w_nx;
                r_fl[1] <= w_ny;
                r_fl[2] <= w_nz;
            end
        end
        if (i_cmd.spd) begin
            r_pos[i_cmd.axis] <= w_pos;
            r_tip[i_cmd.axis] <= w_tip;
            r_spd[i_cmd.axis] <= w_spd;
        end
        if (i_cmd.acc) begin
            r_acc[i_cmd.axis] <= w_acc;
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_pack;
        end
    end

    // tick history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prev_pos[k] <= '0;
                r_prev_spd[k] <= '0;
            end
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.spd) begin
                r_prev_pos[i_cmd.axis] <= w_pos;
            end
            if (i_cmd.acc) begin
                r_prev_spd[i_cmd.axis] <= r_spd[i_cmd.axis];
            end
            if (i_cmd.out_load) begin
                r_first     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_full = r_out_valid & ~i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

endmodule

### design/afk_ctrl.sv
module afk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  afk_pkg::t_status  i_status,
    output logic              o_s_tready,
    output afk_pkg::t_cmd     o_cmd
);
    import afk_pkg::*;

    t_state             r_state, n_state;
    logic [JOINT_W-1:0] r_joint;
    logic [STEP_W-1:0]  r_step;
    logic [ROT_W-1:0]   r_rot;
    logic [AXIS_W-1:0]  r_axis;

    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);
    localparam logic [ROT_W-1:0]   LAST_ROT   = ROT_W'(NUM_ROT - 1);
    localparam logic [AXIS_W-1:0]  LAST_AXIS  = AXIS_W'(NUM_AXES - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_LOAD;
            S_LOAD:   n_state = S_ITER;
            S_ITER:   if (r_step == LAST_STEP) n_state = S_STORE;
            S_STORE:  n_state = (r_joint == LAST_JOINT) ? S_ROT1 : S_LOAD;
            S_ROT1:   n_state = S_ROT2;
            S_ROT2:   n_state = S_ROT3;
            S_ROT3:   n_state = (r_rot == LAST_ROT) ? S_SPD : S_ROT1;
            S_SPD:    n_state = S_ACC;
            S_ACC:    n_state = (r_axis == LAST_AXIS) ? S_FINISH : S_SPD;
            S_FINISH: if (!i_status.out_full) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.joint = r_joint;
        o_cmd.step  = r_step;
        o_cmd.rot   = r_rot;
        o_cmd.axis  = r_axis;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_LOAD:   o_cmd.cordic_load = 1'b1;
            S_ITER:   o_cmd.cordic_step = 1'b1;
            S_STORE:  o_cmd.cs_store    = 1'b1;
            S_ROT1:   o_cmd.rot1        = 1'b1;
            S_ROT2:   o_cmd.rot2        = 1'b1;
            S_ROT3:   o_cmd.rot3        = 1'b1;
            S_SPD:    o_cmd.spd         = 1'b1;
            S_ACC:    o_cmd.acc         = 1'b1;
            S_FINISH: o_cmd.out_load    = ~i_status.out_full;
            default:  o_cmd.accept      = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_joint <= '0;
            r_step  <= '0;
            r_rot   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_joint <= '0;
                    r_step  <= '0;
                    r_rot   <= '0;
                    r_axis  <= '0;
                end
                S_ITER:  r_step  <= (r_step == LAST_STEP) ? '0 : r_step + 1'b1;
                S_STORE: r_joint <= r_joint + 1'b1;
                S_ROT3:  r_rot   <= r_rot + 1'b1;
                S_ACC:   r_axis  <= r_axis + 1'b1;
                default: r_rot   <= r_rot;
            endcase
        end
    end

endmodule

### design/arm_forward_kinematics.sv
// Channel   Dir  Handshake              Payload
// s stream  in   i_s_tvalid/o_s_tready  i_s_tdata: six joint angles, Q3.12
// m stream  out  o_m_tvalid/i_m_tready  o_m_tdata: tip, flange, speed, accel
// config    in   psel/penable/pwrite    paddr, pwdata, prdata; pready tied high
//
// A tick steps through idle, then load, CORDIC iterations and store for each joint,
// then the rotations, a speed and an accel step for each axis, and finish.
// Each joint uses the shared CORDIC for 16 iterations, then nine rotations run
// through one pair of multipliers, each in the ROT1, ROT2 and ROT3 states.
// The result sits in an output register, so a new tick is taken while it waits;
// the finish step stalls only if the previous result has not been taken.
// Reset is synchronous, active low: clears the history, sets the first-tick flag
// and loads the register defaults.
module arm_forward_kinematics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] angle_base, [31:16] angle_shoulder, [47:32] angle_elbow,
    // [63:48] angle_wrist_roll, [79:64] angle_wrist_pitch, [95:80] angle_flange_roll
    input  logic [afk_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [19:0] tip_x, [39:20] tip_y, [59:40] tip_z, [79:60] flange_x,
    // [99:80] flange_y, [119:100] flange_z, [144:120] speed_x, [169:145] speed_y,
    // [194:170] speed_z, [226:195] accel_x, [258:227] accel_y, [290:259] accel_z
    output logic [afk_pkg::OUT_W-1:0]     o_m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afk_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import afk_pkg::*;

    t_cfg     r_cfg;
    t_cmd     w_cmd;
    t_status  w_status;
    t_reg_idx w_reg;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_arm <= RST_UPPER_ARM;
            r_cfg.forearm   <= RST_FOREARM;
            r_cfg.tool      <= RST_TOOL;
            r_cfg.rate      <= RST_RATE;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_UPPER_ARM: r_cfg.upper_arm <= pwdata[CFG_W-1:0];
                REG_FOREARM:   r_cfg.forearm   <= pwdata[CFG_W-1:0];
                REG_TOOL:      r_cfg.tool      <= pwdata[CFG_W-1:0];
                REG_RATE:      r_cfg.rate      <= pwdata[CFG_W-1:0];
                default:       r_cfg.rate      <= r_cfg.rate;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_UPPER_ARM: prdata = 32'(r_cfg.upper_arm);
            REG_FOREARM:   prdata = 32'(r_cfg.forearm);
            REG_TOOL:      prdata = 32'(r_cfg.tool);
            REG_RATE:      prdata = 32'(r_cfg.rate);
            default:       prdata = '0;
        endcase
    end

    afk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    afk_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (r_cfg),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // a taken tick closes the input until the sequence returns to idle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready while a tick is in progress");

    // result register is loaded only when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_m_tvalid && !i_m_tready))
        else $error("pending result overwritten");

    // a new result appears only out of the finish step
    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid ##1 o_m_tvalid) |-> $past(w_cmd.out_load))
        else $error("result valid without a finished tick");

endmodule
